// ===== rtl/bee_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bee_pkg: shared types and helpers for the byte escape encoder
// Character constants, the queued item record and the escape classifier.
// ----------------------------------------------------------------------------
package bee_pkg;

	localparam int QDepth = 2;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	localparam logic [7:0] ChBackslash = 8'h5C;
	localparam logic [7:0] ChX         = 8'h78;
	localparam logic [7:0] ChPrintLo   = 8'h20;
	localparam logic [7:0] ChPrintHi   = 8'h7E;
	localparam logic [7:0] ChEsc       = 8'h1B;
	localparam logic [7:0] HiNibMask   = 8'hF0;
	localparam logic [7:0] LoNibMask   = 8'h0F;

	// number of characters in a run, minus one
	localparam logic [1:0] LastOne  = 2'd0;
	localparam logic [1:0] LastTwo  = 2'd1;
	localparam logic [1:0] LastFour = 2'd3;

	typedef struct packed {
		logic [3:0][7:0] chars;     // chars[0] goes out first
		logic [1:0]      last_idx;
		logic            str_end;
	} esc_item_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] letter;
	} short_esc_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] v;
		v = {4'h0, nib};
		return (nib <= 4'd9) ? (8'h30 + v) : (8'h37 + v);
	endfunction

	function automatic short_esc_t short_letter(input logic [7:0] b);
		short_esc_t r;
		r.hit = 1'b1;
		unique case (b)
			8'h00:       r.letter = 8'h30;
			8'h07:       r.letter = 8'h61;
			8'h08:       r.letter = 8'h62;
			ChEsc:       r.letter = 8'h65;
			8'h0C:       r.letter = 8'h66;
			8'h0A:       r.letter = 8'h6E;
			8'h0D:       r.letter = 8'h72;
			8'h09:       r.letter = 8'h74;
			8'h0B:       r.letter = 8'h76;
			ChBackslash: r.letter = ChBackslash;
			default: begin
				r.hit    = 1'b0;
				r.letter = 8'h00;
			end
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/bee_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bee_front: request intake and classification
// Turns one raw byte into a record of up to four characters for the queue.
// ----------------------------------------------------------------------------
module bee_front import bee_pkg::*; (
	input  wire logic      byte_valid,
	output logic           byte_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic      string_end,
	input  wire logic      q_full,
	output logic           push,
	output esc_item_t      push_item
);

	short_esc_t se;
	logic       printable;

	assign byte_ready = !q_full;
	assign push       = byte_valid && !q_full;
	assign se         = short_letter(data_byte);
	assign printable  = (data_byte >= ChPrintLo) && (data_byte <= ChPrintHi);

	always_comb begin
		push_item.str_end = string_end;
		push_item.chars   = '0;
		if (se.hit) begin
			push_item.chars[0] = ChBackslash;
			push_item.chars[1] = se.letter;
			push_item.last_idx = LastTwo;
		end else if (printable) begin
			push_item.chars[0] = data_byte;
			push_item.last_idx = LastOne;
		end else begin
			push_item.chars[0] = ChBackslash;
			push_item.chars[1] = ChX;
			push_item.chars[2] = hex_char(4'((data_byte & HiNibMask) >> 4));
			push_item.chars[3] = hex_char(4'(data_byte & LoNibMask));
			push_item.last_idx = LastFour;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/bee_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bee_queue: short queue between front and back
// Holds classified records so intake and character output stall apart.
// ----------------------------------------------------------------------------
module bee_queue import bee_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire esc_item_t push_item,
	input  wire logic      pop,
	output logic           full,
	output logic           head_valid,
	output esc_item_t      head_item
);

	esc_item_t        mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] count_q;

	assign full       = (count_q == QCntW'(QDepth));
	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !head_valid))
		else $error("queue pop while empty");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not advance on push");

endmodule
`default_nettype wire

// ===== rtl/bee_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bee_back: character serializer
// Drains head records to an output register, one char per cycle unless stalled.
// ----------------------------------------------------------------------------
module bee_back import bee_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      head_valid,
	input  wire esc_item_t head_item,
	output logic           pop,
	output logic           char_valid,
	input  wire logic      char_ready,
	output logic [7:0]     out_char,
	output logic           run_last,
	output logic           string_done
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       run_last_q;
	logic       string_done_q;
	logic       load;
	logic       at_last;

	assign load    = head_valid && (!out_valid_q || char_ready);
	assign at_last = (idx_q == head_item.last_idx);
	assign pop     = load && at_last;

	assign char_valid  = out_valid_q;
	assign out_char    = out_char_q;
	assign run_last    = run_last_q;
	assign string_done = string_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= at_last ? 2'd0 : idx_q + 1'b1;
			end else if (char_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload: hold while stalled
	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q    <= head_item.chars[idx_q];
			run_last_q    <= at_last;
			string_done_q <= at_last && head_item.str_end;
		end
	end

	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (idx_q <= head_item.last_idx))
		else $error("character index beyond end of run");

	a_idx_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (idx_q == 2'd0))
		else $error("character index not rewound after run");

endmodule
`default_nettype wire

// ===== rtl/byte_escape_encoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// byte_escape_encoder: backslash and hex escape encoder
// Raw bytes in, printable escaped characters out, one per cycle unless stalled.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  byte in   byte_valid/byte_ready  data_byte, string_end
//  char out  char_valid/char_ready  out_char, run_last, string_done
//
//  A printable byte gives one character, a short escape two, a hex escape
//  four; the serializer emits one character per cycle unless stalled.
//  A byte is written into the queue, then its first character is registered.
//  A two-entry queue lets intake run on while the serializer drains a run.
//  Reset clears the queue and the output valid flag; no clearing pass.
// ----------------------------------------------------------------------------
module byte_escape_encoder import bee_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       string_end,
	output logic            char_valid,
	input  wire logic       char_ready,
	output logic [7:0]      out_char,
	output logic            run_last,
	output logic            string_done
);

	logic      q_full;
	logic      push;
	logic      pop;
	logic      head_valid;
	esc_item_t push_item;
	esc_item_t head_item;

	bee_front u_front (
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.data_byte  (data_byte),
		.string_end (string_end),
		.q_full     (q_full),
		.push       (push),
		.push_item  (push_item)
	);

	bee_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	bee_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_item   (head_item),
		.pop         (pop),
		.char_valid  (char_valid),
		.char_ready  (char_ready),
		.out_char    (out_char),
		.run_last    (run_last),
		.string_done (string_done)
	);

endmodule
`default_nettype wire
